### rtl/literal_ngram_window_extractor_top_macros.svh
// Assertion helpers for the n-gram window extractor.
// Both macros expect signals named clk and rst in the enclosing scope.
`ifndef LITERAL_NGRAM_WINDOW_EXTRACTOR_TOP_MACROS_SVH
`define LITERAL_NGRAM_WINDOW_EXTRACTOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define LNWE_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("n-gram extractor check failed");

// The condition must hold in the cycle after reset is seen.
`define LNWE_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("n-gram extractor reset check failed");

`endif

### rtl/lnwe_pkg.sv
package lnwe_pkg;

  // Field widths.
  localparam int CHAR_W      = 8;
  localparam int SEQ_ID_W    = 32;
  localparam int NGRAM_LEN_W = 6;
  localparam int KEY_W       = 64;
  localparam int COUNT_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;

  // Stream packing.
  localparam int IN_TDATA_W  = CHAR_W + SEQ_ID_W;
  localparam int OUT_TDATA_W = KEY_W + SEQ_ID_W + COUNT_W;
  localparam int OUT_TUSER_W = 2;
  localparam int TUSER_EMIT  = 0;
  localparam int TUSER_OP    = 1;

  // Register reset values and limits.
  localparam logic [NGRAM_LEN_W-1:0] NGRAM_LENGTH_RESET = 6'd8;
  localparam logic [NGRAM_LEN_W-1:0] RUN_MAX            = '1;
  localparam logic [COUNT_W-1:0]     COUNT_MAX          = '1;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Characters with special meaning.
  localparam logic [CHAR_W-1:0] CHAR_QUOTE     = 8'h22;
  localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CHAR_LBRACE    = 8'h7B;
  localparam logic [CHAR_W-1:0] CHAR_RBRACE    = 8'h7D;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_NGRAM_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OPERATION    = 2'd1;

  typedef enum logic [1:0] {
    MODE_OUTSIDE = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_ESCAPE  = 2'd2,
    MODE_HEX     = 2'd3
  } read_mode_t;

  // One classified character as it travels from front to back.
  typedef struct packed {
    logic                clear_run;
    logic                take_byte;
    logic [CHAR_W-1:0]   data_byte;
    logic [SEQ_ID_W-1:0] sequence_id;
    logic                last_char;
  } char_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Returns {valid, nibble} for an ASCII hex digit.
  function automatic logic [4:0] hex_nibble(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] diff;
    diff = '0;
    if (ch inside {[8'h61:8'h66]}) begin
      diff = ch - 8'h57;
      return {1'b1, diff[3:0]};
    end else if (ch inside {[8'h41:8'h46]}) begin
      diff = ch - 8'h37;
      return {1'b1, diff[3:0]};
    end else if (ch inside {[8'h30:8'h39]}) begin
      return {1'b1, ch[3:0]};
    end
    return 5'b0;
  endfunction

endpackage

### rtl/lnwe_front.sv
module lnwe_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata fields from bit 0: char_byte[7:0], sequence_id[39:8]
  input  logic [lnwe_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                 s_tlast,
  input  lnwe_pkg::queue_status_t q_status,
  output logic                 push,
  output lnwe_pkg::char_item_t push_item
);
  import lnwe_pkg::*;

  read_mode_t        mode, mode_next;
  logic [CHAR_W-1:0] hex_first, hex_first_next;
  logic              hex_pending, hex_pending_next;
  logic [CHAR_W-1:0] ch;
  logic [4:0]        lo_dig, hi_dig;

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;
  assign ch       = s_tdata[CHAR_W-1:0];
  assign lo_dig   = hex_nibble(hex_first);
  assign hi_dig   = hex_nibble(ch);

  // Next literal mode and held hex digit.
  always_comb begin
    mode_next        = mode;
    hex_first_next   = hex_first;
    hex_pending_next = hex_pending;
    case (mode)
      MODE_OUTSIDE: begin
        if (ch == CHAR_QUOTE) begin
          mode_next = MODE_STRING;
        end else if (ch == CHAR_LBRACE) begin
          mode_next = MODE_HEX;
        end
      end
      MODE_STRING: begin
        if (ch == CHAR_BACKSLASH) begin
          mode_next = MODE_ESCAPE;
        end else if (ch == CHAR_QUOTE) begin
          mode_next = MODE_OUTSIDE;
        end
      end
      MODE_ESCAPE: begin
        mode_next = MODE_STRING;
      end
      MODE_HEX: begin
        // A closing brace keeps any held first digit for the next literal.
        if (ch == CHAR_RBRACE) begin
          mode_next = MODE_OUTSIDE;
        end else if (!hex_pending) begin
          hex_first_next   = ch;
          hex_pending_next = 1'b1;
        end else begin
          hex_pending_next = 1'b0;
        end
      end
      default: begin
        mode_next = MODE_OUTSIDE;
      end
    endcase
  end

  // Classification handed to the back end.
  always_comb begin
    push_item             = '0;
    push_item.sequence_id = s_tdata[IN_TDATA_W-1:CHAR_W];
    push_item.last_char   = s_tlast;
    push_item.data_byte   = ch;
    case (mode)
      MODE_OUTSIDE: begin
        push_item.clear_run = 1'b1;
      end
      MODE_STRING: begin
        push_item.take_byte = (ch != CHAR_BACKSLASH) && (ch != CHAR_QUOTE);
      end
      MODE_ESCAPE: begin
        push_item.take_byte = 1'b1;
      end
      MODE_HEX: begin
        // The first digit of a pair is the low nibble.
        push_item.data_byte = {hi_dig[3:0], lo_dig[3:0]};
        push_item.take_byte = (ch != CHAR_RBRACE) && hex_pending && lo_dig[4] && hi_dig[4];
      end
      default: begin
        push_item.clear_run = 1'b1;
      end
    endcase
  end

  // Parser state advances on each request; the line end clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_OUTSIDE;
      hex_first   <= '0;
      hex_pending <= 1'b0;
    end else if (push) begin
      if (s_tlast) begin
        mode        <= MODE_OUTSIDE;
        hex_first   <= '0;
        hex_pending <= 1'b0;
      end else begin
        mode        <= mode_next;
        hex_first   <= hex_first_next;
        hex_pending <= hex_pending_next;
      end
    end
  end

endmodule

### rtl/lnwe_queue.sv
module lnwe_queue #(
  parameter int DEPTH = lnwe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  lnwe_pkg::char_item_t    push_item,
  input  logic                    pop,
  output lnwe_pkg::char_item_t    pop_item,
  output lnwe_pkg::queue_status_t status
);
  import lnwe_pkg::*;

  // DEPTH from 2 upward.
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  char_item_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_item     = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/lnwe_back.sv
module lnwe_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [lnwe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lnwe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  lnwe_pkg::queue_status_t q_status,
  input  lnwe_pkg::char_item_t q_item,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata fields from bit 0: ngram_key[63:0], key_sequence_id[95:64],
  // line_ngram_count[111:96]
  output logic [lnwe_pkg::OUT_TDATA_W-1:0] m_tdata,
  // m_tuser fields from bit 0: emit[0], key_operation[1]
  output logic [lnwe_pkg::OUT_TUSER_W-1:0] m_tuser,
  output logic                 m_tlast
);
  import lnwe_pkg::*;

  logic [NGRAM_LEN_W-1:0] ngram_length;
  logic                   operation;
  logic [KEY_W-1:0]       window, window_next;
  logic [NGRAM_LEN_W-1:0] run_length, run_next;
  logic [COUNT_W-1:0]     ngram_count, count_next;
  logic                   emit_next;

  assign cfg_ready = 1'b1;
  assign pop       = !q_status.empty && (!m_tvalid || m_tready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ngram_length <= NGRAM_LENGTH_RESET;
      operation    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NGRAM_LENGTH: ngram_length <= cfg_data;
        REG_OPERATION:    operation    <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Window shift, run count and key count for the item at the queue head.
  always_comb begin
    window_next = window;
    run_next    = run_length;
    count_next  = ngram_count;
    emit_next   = 1'b0;
    if (q_item.clear_run) begin
      run_next = '0;
    end else if (q_item.take_byte) begin
      window_next = {q_item.data_byte, window[KEY_W-1:CHAR_W]};
      run_next    = (run_length == RUN_MAX) ? run_length : run_length + 1'b1;
      emit_next   = (run_next >= ngram_length);
      if (emit_next && (ngram_count != COUNT_MAX)) begin
        count_next = ngram_count + 1'b1;
      end
    end
  end

  // Line state; cleared after the last character of a line.
  always_ff @(posedge clk) begin
    if (rst) begin
      window      <= '0;
      run_length  <= '0;
      ngram_count <= '0;
    end else if (pop) begin
      if (q_item.last_char) begin
        window      <= '0;
        run_length  <= '0;
        ngram_count <= '0;
      end else begin
        window      <= window_next;
        run_length  <= run_next;
        ngram_count <= count_next;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata              <= {count_next, q_item.sequence_id, window_next};
      m_tuser[TUSER_EMIT]  <= emit_next;
      m_tuser[TUSER_OP]    <= operation;
      m_tlast              <= q_item.last_char;
    end
  end

endmodule

### rtl/literal_ngram_window_extractor_top.sv
// Literal n-gram window extractor. Takes one character of a text line per
// request on the s_ side and gives exactly one result per character on the
// m_ side. Characters inside double quotes (with backslash escapes) and hex
// pairs inside braces shift into a 64-bit window; once the run of contiguous
// bytes reaches ngram_length, the result carries emit = 1 and the window as
// a key. The block sustains one character per cycle while the output is not
// stalled. Each character is classified as it is taken, held in a queue of
// QUEUE_DEPTH entries, and then updates the window as its result is written
// into the output register. Configuration writes are always taken (cfg_ready
// stays high) and should be made while no line is in flight.
`include "literal_ngram_window_extractor_top_macros.svh"

module literal_ngram_window_extractor_top #(
  parameter int QUEUE_DEPTH = lnwe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // s_tdata fields from bit 0: char_byte[7:0], sequence_id[39:8]
  input  logic [lnwe_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // m_tdata fields from bit 0: ngram_key[63:0], key_sequence_id[95:64],
  // line_ngram_count[111:96]
  output logic [lnwe_pkg::OUT_TDATA_W-1:0] m_tdata,
  // m_tuser fields from bit 0: emit[0], key_operation[1]
  output logic [lnwe_pkg::OUT_TUSER_W-1:0] m_tuser,
  output logic m_tlast,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [lnwe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lnwe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lnwe_pkg::*;

  logic          push, pop;
  char_item_t    push_item, pop_item;
  queue_status_t q_status;

  // Parser: tracks literal mode and classifies each character.
  lnwe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // Queue of classified characters.
  lnwe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // Window, run and key count, with the output register.
  lnwe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .q_item    (pop_item),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // A result that carries a key has counted at least that key.
  `LNWE_ASSERT_HOLDS(a_emit_counted, m_tvalid && m_tuser[TUSER_EMIT], m_tdata[OUT_TDATA_W-1 -: COUNT_W] != '0)
  // The queue cannot report full and empty together.
  `LNWE_ASSERT_HOLDS(a_queue_status, 1'b1, !(q_status.full && q_status.empty))
  // Reset leaves no result pending and the queue empty and open.
  `LNWE_ASSERT_AFTER_RESET(a_reset_idle, !m_tvalid && q_status.empty && s_tready)

endmodule
